// ----- rtl/mltok_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mltok_pkg
// Types, character codes and the per-character segment step of the metric
// line tokeniser.
// ---------------------------------------------------------------------------
package mltok_pkg;

  localparam int TAG_COUNT_MAX_DEF = 255;

  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam int NF_SIGN = 0;
  localparam int NF_NUM  = 1;
  localparam int NF_DOT  = 2;
  localparam int NF_EXP  = 3;

  localparam logic [3:0] NF_RESET = 4'b1101;

  localparam logic [1:0] KIND_COUNTER  = 2'd0;
  localparam logic [1:0] KIND_GAUGE    = 2'd1;
  localparam logic [1:0] KIND_DURATION = 2'd2;

  localparam logic [1:0] SGN_NONE = 2'd0;
  localparam logic [1:0] SGN_POS  = 2'd1;
  localparam logic [1:0] SGN_NEG  = 2'd2;
  localparam logic [1:0] SGN_EXP  = 2'd3;

  typedef enum logic [2:0] {
    SEG_NAME = 3'd0,
    SEG_KEY  = 3'd1,
    SEG_VAL  = 3'd2,
    SEG_NUM  = 3'd3,
    SEG_TYPE = 3'd4,
    SEG_DIV  = 3'd5
  } seg_t;

  typedef enum logic [2:0] {
    CLS_NAME     = 3'd0,
    CLS_KEY      = 3'd1,
    CLS_VAL      = 3'd2,
    CLS_NUM      = 3'd3,
    CLS_TYPE     = 3'd4,
    CLS_DIVIDER  = 3'd5,
    CLS_DELIM    = 3'd6,
    CLS_REJECTED = 3'd7
  } cls_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       line_end;
  } char_word_t;

  typedef struct packed {
    logic [2:0] segment_class;
    logic       line_done;
    logic       line_valid;
    logic [1:0] metric_kind;
    logic [1:0] value_sign;
    logic [7:0] tag_pairs;
  } result_word_t;

  typedef struct packed {
    seg_t       seg;
    logic [1:0] pos;
    logic [3:0] nflags;
    logic       after_type;
    logic [1:0] type_first;
    logic [1:0] csign;
    logic       err;
    logic [7:0] tags;
  } tok_state_t;

  typedef struct packed {
    tok_state_t st;
    cls_t       cls;
  } step_t;

  localparam tok_state_t TOK_RESET = '{
    seg: SEG_NAME, pos: 2'd0, nflags: NF_RESET, after_type: 1'b0,
    type_first: KIND_COUNTER, csign: SGN_NONE, err: 1'b0, tags: 8'd0
  };

  function automatic step_t step_char(tok_state_t s, logic [7:0] c, logic term,
                                      logic [7:0] limit);
    step_t r;
    logic  alpha;
    logic  digit;
    logic  word;
    logic  is_comma;
    logic  is_colon;
    logic  is_eq;
    logic  is_bar;
    logic  is_hash;
    logic  is_pm;
    logic  is_e;
    logic  is_dot;
    logic  is_m;
    logic  p0z;
    alpha    = !term && ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A));
    digit    = !term && (c >= 8'h30 && c <= 8'h39);
    word     = alpha || digit || (!term && (c == CH_DOT || c == CH_UNDER));
    is_comma = !term && c == CH_COMMA;
    is_colon = !term && c == CH_COLON;
    is_eq    = !term && c == CH_EQ;
    is_bar   = !term && c == CH_BAR;
    is_hash  = !term && c == CH_HASH;
    is_pm    = !term && (c == CH_PLUS || c == CH_MINUS);
    is_e     = !term && (c == CH_E_LO || c == CH_E_UP);
    is_dot   = !term && c == CH_DOT;
    is_m     = !term && c == CH_M;
    p0z      = (s.pos == 2'd0);
    r.st     = s;
    r.cls    = CLS_REJECTED;
    if (s.err) begin
      r.cls = CLS_REJECTED;
    end else begin
      case (s.seg)
        SEG_NAME: begin
          if (p0z) begin
            if (alpha) begin
              r.st.pos = 2'd1;
              r.cls    = CLS_NAME;
            end else begin
              r.st.err = 1'b1;
            end
          end else if (word) begin
            r.cls = CLS_NAME;
          end else if (is_comma || is_colon) begin
            r.st.seg = is_comma ? SEG_KEY : SEG_NUM;
            r.st.pos = 2'd0;
            r.cls    = CLS_DELIM;
          end else begin
            r.st.err = 1'b1;
          end
        end
        SEG_KEY: begin
          if (word) begin
            r.cls = CLS_KEY;
          end else if (is_eq || (s.after_type && is_colon)) begin
            r.st.seg = SEG_VAL;
            r.st.pos = 2'd0;
            r.cls    = CLS_DELIM;
          end else begin
            r.st.err = 1'b1;
          end
        end
        SEG_VAL: begin
          if (word) begin
            r.cls = CLS_VAL;
          end else if (is_comma || is_colon || (s.after_type && term)) begin
            if (s.tags < limit) r.st.tags = s.tags + 8'd1;
            r.st.seg = is_comma ? SEG_KEY : SEG_NUM;
            r.st.pos = 2'd0;
            r.cls    = CLS_DELIM;
          end else begin
            r.st.err = 1'b1;
          end
        end
        SEG_NUM: begin
          if (p0z) begin
            if (!term && c == CH_PLUS)       r.st.csign = SGN_POS;
            else if (!term && c == CH_MINUS) r.st.csign = SGN_NEG;
            else if (is_e)                   r.st.csign = SGN_EXP;
            else                             r.st.csign = SGN_NONE;
          end
          if (s.pos != 2'd3) r.st.pos = s.pos + 2'd1;
          if (s.nflags[NF_SIGN] && is_pm) begin
            r.st.nflags[NF_SIGN] = 1'b0;
            r.cls = CLS_NUM;
          end else if (digit) begin
            r.st.nflags[NF_SIGN] = 1'b0;
            r.st.nflags[NF_NUM]  = 1'b1;
            r.cls = CLS_NUM;
          end else if (!s.nflags[NF_NUM]) begin
            r.st.err = 1'b1;
          end else if (is_dot && s.nflags[NF_DOT]) begin
            r.st.nflags[NF_NUM] = 1'b0;
            r.st.nflags[NF_DOT] = 1'b0;
            r.cls = CLS_NUM;
          end else if (is_e && s.nflags[NF_EXP]) begin
            r.st.nflags = 4'b0001;
            r.cls = CLS_NUM;
          end else if (is_bar) begin
            if (p0z || r.st.csign == SGN_EXP) begin
              r.st.err = 1'b1;
            end else begin
              r.st.seg = SEG_TYPE;
              r.st.pos = 2'd0;
              r.cls    = CLS_DELIM;
            end
          end else begin
            r.st.err = 1'b1;
          end
        end
        SEG_TYPE: begin
          if (p0z && (is_m || (!term && (c == CH_C || c == CH_G)))) begin
            r.st.type_first = is_m ? KIND_DURATION :
                              (c == CH_G) ? KIND_GAUGE : KIND_COUNTER;
            r.st.pos = 2'd1;
            r.cls    = CLS_TYPE;
          end else if (s.pos == 2'd1 && !term && c == CH_S &&
                       s.type_first == KIND_DURATION) begin
            r.st.pos = 2'd2;
            r.cls    = CLS_TYPE;
          end else if (!p0z && term) begin
            r.cls = CLS_DELIM;
          end else if (is_bar) begin
            if (p0z) r.st.type_first = KIND_COUNTER;
            r.st.seg = SEG_DIV;
            r.st.pos = 2'd0;
            r.cls    = CLS_DELIM;
          end else begin
            r.st.err = 1'b1;
          end
        end
        SEG_DIV: begin
          if (p0z && is_bar) begin
            r.st.pos = 2'd1;
            r.cls    = CLS_DIVIDER;
          end else if (is_hash) begin
            r.st.seg        = SEG_KEY;
            r.st.after_type = 1'b1;
            r.st.pos        = 2'd0;
            r.cls           = CLS_DELIM;
          end else begin
            r.st.err = 1'b1;
          end
        end
        default: begin
          r.st.err = 1'b1;
        end
      endcase
    end
    return r;
  endfunction

endpackage

// ----- rtl/mltok_in_stage.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mltok_in_stage
// Input register of the tokeniser: holds one character word until the
// step stage takes it.
// ---------------------------------------------------------------------------
module mltok_in_stage
  import mltok_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  char_word_t char_word,
  input  logic       take,
  output logic       held_valid,
  output char_word_t held_word
);

  assign char_stall = held_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!char_stall) begin
      held_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!char_stall && char_valid) begin
      held_word <= char_word;
    end
  end

endmodule

// ----- rtl/mltok_step.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mltok_step
// Line state and result register: classifies the held character, runs the
// end-of-line terminator on the final one and registers the result word.
// ---------------------------------------------------------------------------
module mltok_step
  import mltok_pkg::*;
#(
  parameter int TAG_COUNT_MAX = TAG_COUNT_MAX_DEF
)
(
  input  logic         clk,
  input  logic         rst,
  input  logic         held_valid,
  input  char_word_t   held_word,
  output logic         take,
  output logic         result_valid,
  input  logic         result_stall,
  output result_word_t result_word
);

  localparam int TAG_LIMIT_INT = (TAG_COUNT_MAX < 255) ? TAG_COUNT_MAX : 255;
  localparam logic [7:0] TAG_LIMIT = TAG_LIMIT_INT[7:0];

  tok_state_t   st;
  tok_state_t   st_next;
  step_t        first;
  step_t        second;
  logic         lf_term;
  result_word_t word_next;

  assign take = held_valid && (!result_valid || !result_stall);
  assign lf_term = held_word.line_end && (held_word.char_byte == CH_LF);

  always_comb begin
    first  = step_char(st, held_word.char_byte, lf_term, TAG_LIMIT);
    second = first;
    if (held_word.line_end && !lf_term) begin
      second = step_char(first.st, held_word.char_byte, 1'b1, TAG_LIMIT);
    end
    st_next = held_word.line_end ? TOK_RESET : first.st;
    word_next = '0;
    word_next.segment_class = first.cls;
    word_next.line_done     = held_word.line_end;
    if (held_word.line_end && !second.st.err) begin
      word_next.line_valid  = 1'b1;
      word_next.metric_kind = second.st.type_first;
      word_next.value_sign  = second.st.csign;
      word_next.tag_pairs   = second.st.tags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= TOK_RESET;
    end else if (take) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_word <= word_next;
    end
  end

  a_line_clears: assert property (@(posedge clk) disable iff (rst)
    take && held_word.line_end |=> st == TOK_RESET)
    else $error("line state not cleared after final character");

  a_err_rejects: assert property (@(posedge clk) disable iff (rst)
    take && st.err && !held_word.line_end |=>
      result_word.segment_class == CLS_REJECTED)
    else $error("character after an error not rejected");

  a_take_gives_result: assert property (@(posedge clk) disable iff (rst)
    take |=> result_valid)
    else $error("taken character produced no result");

  a_verdict_only_at_end: assert property (@(posedge clk) disable iff (rst)
    take && !held_word.line_end |=> !result_word.line_valid && result_word.tag_pairs == 8'd0)
    else $error("verdict fields set before final character");

endmodule

// ----- rtl/metric_line_tokenizer_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// metric_line_tokenizer_unit
// Syntax checker for metric text lines, one character per word.
//
// Feed characters on the char channel, line_end set on the last one of a
// line; a final newline is taken as the line terminator itself. Every
// character yields one word on the result channel with its segment class;
// the word of the final character also carries the verdict, metric kind,
// explicit sign and saturating tag pair count.
// Both channels handshake on valid and stall: a word moves on an edge with
// valid high and stall low.
// The input register loads a character on the accepting edge; the result
// register loads its word when the step stage takes that character.
// Throughput: one character per cycle while the result channel is not
// stalled, as the line state register updates on every taken character.
// A stalled result is held while one more character waits in the input
// register; only then is the char channel stalled.
// Reset empties both registers and returns the line state to the start of
// a name; the line state alone returns there after every final character.
// ---------------------------------------------------------------------------
module metric_line_tokenizer_unit
  import mltok_pkg::*;
#(
  parameter int TAG_COUNT_MAX = TAG_COUNT_MAX_DEF
)
(
  input  logic         clk,
  input  logic         rst,
  input  logic         char_valid,
  output logic         char_stall,
  input  char_word_t   char_word,
  output logic         result_valid,
  input  logic         result_stall,
  output result_word_t result_word
);

  logic       take;
  logic       held_valid;
  char_word_t held_word;

  mltok_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_word  (char_word),
    .take       (take),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  mltok_step #(
    .TAG_COUNT_MAX (TAG_COUNT_MAX)
  ) u_step (
    .clk          (clk),
    .rst          (rst),
    .held_valid   (held_valid),
    .held_word    (held_word),
    .take         (take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

endmodule

// ----- tb/sv/metric_line_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// metric_line_checker
// Watches both channels of the metric line tokeniser and checks every result
// word.
//
// Each accepted character word runs through a local copy of the line syntax
// (segment, number flags, metric kind, sign, tag count, sticky error). The
// word expected back is queued. Each accepted result word is compared field
// by field with the oldest one waiting. The mismatch count and the number of
// words still awaited go to the testbench top.
// ---------------------------------------------------------------------------
module metric_line_checker
  import mltok_pkg::*;
#(
  parameter int TAG_LIMIT = TAG_COUNT_MAX_DEF
)
(
  input  logic         clk,
  input  logic         rst,
  input  logic         char_valid,
  input  logic         char_stall,
  input  char_word_t   char_word,
  input  logic         result_valid,
  input  logic         result_stall,
  input  result_word_t result_word,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    seg_t       seg;
    logic [1:0] pos;
    logic [3:0] nflags;
    logic       after_type;
    logic [1:0] kind;
    logic [1:0] sign;
    logic       err;
    logic [7:0] tags;
  } line_ctx_t;

  localparam line_ctx_t LINE_START = '{
    seg: SEG_NAME, pos: 2'd0, nflags: NF_RESET, after_type: 1'b0,
    kind: KIND_COUNTER, sign: SGN_NONE, err: 1'b0, tags: 8'd0
  };

  localparam int         TAG_CAP_INT = (TAG_LIMIT < 255) ? TAG_LIMIT : 255;
  localparam logic [7:0] TAG_CAP     = TAG_CAP_INT[7:0];

  line_ctx_t    ctx;
  result_word_t awaited_words[$];

  function automatic cls_t flag_error();
    ctx.err = 1'b1;
    return CLS_REJECTED;
  endfunction

  // term stands for the end-of-line terminator, not a character
  function automatic cls_t consume_char(logic [7:0] c, bit term);
    logic [1:0] p0;
    bit         alpha;
    bit         digit;
    bit         wordc;
    bit         comma;
    bit         colon;
    bit         bar;
    bit         plus;
    bit         minus;
    bit         e_char;
    alpha  = !term && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"));
    digit  = !term && c >= "0" && c <= "9";
    wordc  = alpha || digit || (!term && (c == CH_DOT || c == CH_UNDER));
    comma  = !term && c == CH_COMMA;
    colon  = !term && c == CH_COLON;
    bar    = !term && c == CH_BAR;
    plus   = !term && c == CH_PLUS;
    minus  = !term && c == CH_MINUS;
    e_char = !term && (c == CH_E_LO || c == CH_E_UP);
    p0     = ctx.pos;
    if (ctx.err) return CLS_REJECTED;
    case (ctx.seg)
      SEG_NAME: begin
        if (p0 == 2'd0) begin
          if (!alpha) return flag_error();
          ctx.pos = 2'd1;
          return CLS_NAME;
        end
        if (wordc) return CLS_NAME;
        if (comma || colon) begin
          ctx.seg = comma ? SEG_KEY : SEG_NUM;
          ctx.pos = 2'd0;
          return CLS_DELIM;
        end
      end
      SEG_KEY: begin
        if (wordc) return CLS_KEY;
        if ((!term && c == CH_EQ) || (ctx.after_type && colon)) begin
          ctx.seg = SEG_VAL;
          ctx.pos = 2'd0;
          return CLS_DELIM;
        end
      end
      SEG_VAL: begin
        if (wordc) return CLS_VAL;
        if (comma || colon || (ctx.after_type && term)) begin
          if (ctx.tags < TAG_CAP) ctx.tags = ctx.tags + 8'd1;
          ctx.seg = comma ? SEG_KEY : SEG_NUM;
          ctx.pos = 2'd0;
          return CLS_DELIM;
        end
      end
      SEG_NUM: begin
        if (p0 == 2'd0)
          ctx.sign = plus ? SGN_POS : minus ? SGN_NEG : e_char ? SGN_EXP : SGN_NONE;
        if (ctx.pos != 2'd3) ctx.pos = ctx.pos + 2'd1;
        if (ctx.nflags[NF_SIGN] && (plus || minus)) begin
          ctx.nflags[NF_SIGN] = 1'b0;
          return CLS_NUM;
        end
        if (digit) begin
          ctx.nflags[NF_SIGN] = 1'b0;
          ctx.nflags[NF_NUM]  = 1'b1;
          return CLS_NUM;
        end
        if (ctx.nflags[NF_NUM]) begin
          if (!term && c == CH_DOT && ctx.nflags[NF_DOT]) begin
            ctx.nflags[NF_NUM] = 1'b0;
            ctx.nflags[NF_DOT] = 1'b0;
            return CLS_NUM;
          end
          if (e_char && ctx.nflags[NF_EXP]) begin
            ctx.nflags          = 4'b0000;
            ctx.nflags[NF_SIGN] = 1'b1;
            return CLS_NUM;
          end
          if (bar && p0 != 2'd0 && ctx.sign != SGN_EXP) begin
            ctx.seg = SEG_TYPE;
            ctx.pos = 2'd0;
            return CLS_DELIM;
          end
        end
      end
      SEG_TYPE: begin
        if (p0 == 2'd0 && !term && (c == CH_M || c == CH_C || c == CH_G)) begin
          ctx.kind = (c == CH_M) ? KIND_DURATION : (c == CH_G) ? KIND_GAUGE : KIND_COUNTER;
          ctx.pos  = 2'd1;
          return CLS_TYPE;
        end
        if (p0 == 2'd1 && !term && c == CH_S && ctx.kind == KIND_DURATION) begin
          ctx.pos = 2'd2;
          return CLS_TYPE;
        end
        if (p0 != 2'd0 && term) return CLS_DELIM;
        if (bar) begin
          if (p0 == 2'd0) ctx.kind = KIND_COUNTER;
          ctx.seg = SEG_DIV;
          ctx.pos = 2'd0;
          return CLS_DELIM;
        end
      end
      SEG_DIV: begin
        if (p0 == 2'd0 && bar) begin
          ctx.pos = 2'd1;
          return CLS_DIVIDER;
        end
        if (!term && c == CH_HASH) begin
          ctx.seg        = SEG_KEY;
          ctx.after_type = 1'b1;
          ctx.pos        = 2'd0;
          return CLS_DELIM;
        end
      end
      default: ;
    endcase
    return flag_error();
  endfunction

  function automatic result_word_t predict_word(char_word_t w);
    result_word_t r;
    cls_t         cls;
    r = '0;
    if (w.line_end && w.char_byte == CH_LF) begin
      cls = consume_char(8'h00, 1'b1);
    end else begin
      cls = consume_char(w.char_byte, 1'b0);
      if (w.line_end) void'(consume_char(8'h00, 1'b1));
    end
    r.segment_class = cls;
    r.line_done     = w.line_end;
    if (w.line_end) begin
      r.line_valid = !ctx.err;
      if (!ctx.err) begin
        r.metric_kind = ctx.kind;
        r.value_sign  = ctx.sign;
        r.tag_pairs   = ctx.tags;
      end
      ctx = LINE_START;
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    fail_count++;
    if (fail_count <= 40)
      $display("%0t ns: %s got %0d want %0d", $time, field, got, want);
  endtask

  always @(posedge clk) begin
    result_word_t want;
    if (rst) begin
      awaited_words.delete();
      ctx        = LINE_START;
      fail_count = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (awaited_words.size() == 0) begin
          report_mismatch("unexpected result word", int'(result_word), 0);
        end else begin
          want = awaited_words.pop_front();
          if (result_word.segment_class !== want.segment_class)
            report_mismatch("segment_class", int'(result_word.segment_class),
                            int'(want.segment_class));
          if (result_word.line_done !== want.line_done)
            report_mismatch("line_done", int'(result_word.line_done),
                            int'(want.line_done));
          if (result_word.line_valid !== want.line_valid)
            report_mismatch("line_valid", int'(result_word.line_valid),
                            int'(want.line_valid));
          if (result_word.metric_kind !== want.metric_kind)
            report_mismatch("metric_kind", int'(result_word.metric_kind),
                            int'(want.metric_kind));
          if (result_word.value_sign !== want.value_sign)
            report_mismatch("value_sign", int'(result_word.value_sign),
                            int'(want.value_sign));
          if (result_word.tag_pairs !== want.tag_pairs)
            report_mismatch("tag_pairs", int'(result_word.tag_pairs),
                            int'(want.tag_pairs));
        end
      end
      if (char_valid && !char_stall) awaited_words.push_back(predict_word(char_word));
    end
    pending = awaited_words.size();
  end

endmodule

// ----- tb/sv/metric_line_tokenizer_unit_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// metric_line_tokenizer_unit_tb
// Stimulus and verdict for the metric line tokeniser.
//
// A few hand-written lines come first, then random lines: mostly well formed
// with random names, tags, numbers and types, some spoilt or truncated, some
// plain byte noise, and one line whose tag count saturates. Both channels
// idle at random; the sender now and then holds until every result is back.
// Checking is done by metric_line_checker beside the block.
// ---------------------------------------------------------------------------
module metric_line_tokenizer_unit_tb;
  import mltok_pkg::*;

  localparam int CYCLE_LIMIT    = 500000;
  localparam int RANDOM_CHARS   = 860;
  localparam int CROWDED_PAIRS  = 258;

  logic         clk          = 1'b0;
  logic         rst          = 1'b1;
  logic         char_valid   = 1'b0;
  logic         char_stall;
  char_word_t   char_word    = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_word_t result_word;

  int           mismatch_count;
  int           pending;
  int           cycle_count  = 0;
  int           sent_chars   = 0;
  bit           sender_calm  = 1'b0;
  int           stall_hold   = 0;
  bit           stall_level  = 1'b0;
  int           stall_pick;
  logic [7:0]   line_buf[$];

  metric_line_tokenizer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_word    (char_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

  metric_line_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_word    (char_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word),
    .fail_count   (mismatch_count),
    .pending      (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: short free and stalled runs, a few long ones
  always @(negedge clk) begin
    if (stall_hold == 0) begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 55) begin
        stall_level = 1'b0;
        stall_hold  = $urandom_range(1, 8);
      end else if (stall_pick < 67) begin
        stall_level = 1'b0;
        stall_hold  = $urandom_range(50, 200);
      end else if (stall_pick < 95) begin
        stall_level = 1'b1;
        stall_hold  = $urandom_range(1, 3);
      end else begin
        stall_level = 1'b1;
        stall_hold  = $urandom_range(10, 40);
      end
    end
    stall_hold--;
    result_stall <= stall_level;
  end

  function automatic int sender_gap();
    int r;
    if (sender_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_alpha();
    logic [7:0] c;
    c = 8'("a" + $urandom_range(0, 25));
    if ($urandom_range(0, 1)) c = c - 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] pick_word_char();
    case ($urandom_range(0, 5))
      0:       return CH_DOT;
      1:       return CH_UNDER;
      2, 3:    return 8'("0" + $urandom_range(0, 9));
      default: return pick_alpha();
    endcase
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void add_word_chars(int n);
    repeat (n) line_buf.push_back(pick_word_char());
  endfunction

  function automatic void add_digits();
    repeat ($urandom_range(1, 3)) line_buf.push_back(8'("0" + $urandom_range(0, 9)));
  endfunction

  function automatic void add_sign();
    case ($urandom_range(0, 2))
      1:       line_buf.push_back(CH_PLUS);
      2:       line_buf.push_back(CH_MINUS);
      default: ;
    endcase
  endfunction

  function automatic void add_number();
    int form;
    form = $urandom_range(0, 19);
    if (form == 0) begin
      line_buf.push_back($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
      add_digits();
    end else if (form != 1) begin
      add_sign();
      add_digits();
      if ($urandom_range(0, 2) == 0) begin
        line_buf.push_back(CH_DOT);
        add_digits();
      end
      if ($urandom_range(0, 3) == 0) begin
        line_buf.push_back($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
        add_sign();
        add_digits();
      end
    end
  endfunction

  function automatic void add_type(bit may_be_empty);
    case ($urandom_range(0, may_be_empty ? 4 : 3))
      0: line_buf.push_back(CH_C);
      1: line_buf.push_back(CH_G);
      2: line_buf.push_back(CH_M);
      3: begin
        line_buf.push_back(CH_M);
        line_buf.push_back(CH_S);
      end
      default: ;
    endcase
  endfunction

  function automatic void add_tail_tags();
    int pairs;
    pairs = $urandom_range(1, 3);
    line_buf.push_back(CH_BAR);
    if ($urandom_range(0, 1)) line_buf.push_back(CH_BAR);
    line_buf.push_back(CH_HASH);
    for (int i = 0; i < pairs; i++) begin
      if (i != 0) line_buf.push_back(CH_COMMA);
      add_word_chars($urandom_range(0, 3));
      line_buf.push_back($urandom_range(0, 1) ? CH_EQ : CH_COLON);
      add_word_chars($urandom_range(0, 3));
    end
  endfunction

  function automatic void build_metric_line();
    line_buf.push_back(pick_alpha());
    add_word_chars($urandom_range(0, 4));
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        line_buf.push_back(CH_COMMA);
        add_word_chars($urandom_range(0, 3));
        line_buf.push_back(CH_EQ);
        add_word_chars($urandom_range(0, 3));
      end
    end
    line_buf.push_back(CH_COLON);
    add_number();
    line_buf.push_back(CH_BAR);
    if ($urandom_range(0, 2) == 0) begin
      add_type(1'b1);
      add_tail_tags();
      if ($urandom_range(0, 2) == 0) begin
        line_buf.push_back(CH_COLON);
        add_digits();
        line_buf.push_back(CH_BAR);
        add_type(1'b0);
      end
    end else begin
      add_type(1'b0);
    end
  endfunction

  function automatic void build_crowded_line();
    line_buf.push_back(pick_alpha());
    repeat (CROWDED_PAIRS) begin
      line_buf.push_back(CH_COMMA);
      line_buf.push_back(CH_EQ);
    end
    line_buf.push_back(CH_COLON);
    add_digits();
    line_buf.push_back(CH_BAR);
    add_type(1'b0);
  endfunction

  function automatic void build_noise();
    repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
  endfunction

  // overwrite one character or cut the line short
  function automatic void spoil_line();
    int at;
    at = $urandom_range(0, line_buf.size() - 1);
    if ($urandom_range(0, 1))
      line_buf[at] = 8'($urandom_range(0, 255));
    else
      repeat (line_buf.size() - at - 1) line_buf.delete(line_buf.size() - 1);
  endfunction

  task automatic send_char(logic [7:0] c, bit last);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_valid <= 1'b1;
    char_word  <= '{char_byte: c, line_end: last};
    do @(posedge clk); while (char_stall);
    @(negedge clk);
  endtask

  task automatic send_line();
    sender_calm = ($urandom_range(0, 3) == 0);
    foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
    sent_chars += line_buf.size();
    line_buf.delete();
  endtask

  task automatic await_all_results();
    char_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin
    int  pick;
    bit  crowded_done;
    crowded_done = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_text("a:1|c\n");
    send_line();
    add_text("b:-2|ms");
    send_line();
    line_buf = '{"q", 8'h00, CH_LF, CH_LF};
    send_line();
    line_buf = '{"z", 8'hFF};
    send_line();
    add_text("g:5|||#k=v");
    send_line();
    await_all_results();

    sent_chars = 0;
    while (sent_chars < RANDOM_CHARS) begin
      pick = $urandom_range(0, 19);
      if (!crowded_done && sent_chars > 300) begin
        build_crowded_line();
        crowded_done = 1'b1;
      end else if (pick < 14) begin
        build_metric_line();
      end else if (pick < 17) begin
        build_metric_line();
        spoil_line();
      end else begin
        build_noise();
      end
      if (pick < 17 && $urandom_range(0, 1)) line_buf.push_back(CH_LF);
      send_line();
      if ($urandom_range(0, 11) == 0) await_all_results();
    end

    char_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (mismatch_count == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- metric_line_tokenizer_unit.f -----
rtl/mltok_pkg.sv
rtl/mltok_in_stage.sv
rtl/mltok_step.sv
rtl/metric_line_tokenizer_unit.sv
tb/sv/metric_line_checker.sv
tb/sv/metric_line_tokenizer_unit_tb.sv
